>>> src/fbfl_pkg.sv
`default_nettype none

package fbfl_pkg;

    localparam int MAX_BLOCKS_DEF = 256;
    localparam int POOL_BLOCKS_RST = 256;
    localparam logic [15:0] BLOCK_SIZE_RST = 16'd16;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_BLOCKS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE = 4'd1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] block_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  granted_index;
        logic [23:0] granted_offset;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic sweep_start;
        logic sweep_step;
        logic pop_read;
        logic pop_done;
        logic push;
        logic flag_empty;
        logic flag_range;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic list_empty;
        logic range_err;
    } stat_t;

endpackage

`default_nettype wire

>>> src/fbfl_ctrl.sv
`default_nettype none

module fbfl_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire logic          req_func,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    input  wire logic          cfg_count_wr,
    input  wire fbfl_pkg::stat_t stat,
    output fbfl_pkg::cmd_t     cmd
);
    import fbfl_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   accept;

    assign rsp_valid = rsp_valid_reg;
    assign req_stall = (state_reg != S_IDLE) || cfg_count_wr || (rsp_valid_reg && rsp_stall);
    assign accept = req_valid && !req_stall;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_func == FUNC_ALLOC)
                    begin
                        if (stat.list_empty)
                        begin
                            cmd.flag_empty = 1'b1;
                        end
                        else
                        begin
                            cmd.pop_read = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    else if (stat.range_err)
                    begin
                        cmd.flag_range = 1'b1;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.pop_done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        // a new block count rebuilds the chain from scratch
        if (cfg_count_wr)
        begin
            cmd = '0;
            cmd.sweep_start = 1'b1;
            state_next = S_INIT;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.pop_done || cmd.push || cmd.flag_empty || cmd.flag_range)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> src/fbfl_datapath.sv
`default_nettype none

module fbfl_datapath #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire fbfl_pkg::cmd_t                   cmd,
    output fbfl_pkg::stat_t                       stat,
    input  wire logic                             cfg_count_wr,
    input  wire logic                             cfg_size_wr,
    input  wire logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [7:0]                       req_index,
    output fbfl_pkg::rsp_t                        rsp
);
    import fbfl_pkg::*;

    localparam int IDXW = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int CW = (CNTW > 9) ? CNTW : 9;
    localparam int PW = IDXW + 24;

    // link entry: end-of-chain bit over the next block index
    logic [IDXW:0]      link_mem [MAX_BLOCKS];
    logic [IDXW:0]      rd_data_reg;

    logic [IDXW-1:0]    head_reg;
    logic               empty_reg;
    logic [IDXW-1:0]    ptr_reg;
    logic [CNTW-1:0]    count_reg;
    logic [15:0]        size_reg;
    rsp_t               rsp_reg;

    logic [CW-1:0]      cfg_count_cw;
    logic [CW-1:0]      count_clamped;
    logic [CW-1:0]      idx_cw;
    logic [CW-1:0]      ptr_cw;
    logic [CW-1:0]      head_cw;
    logic [IDXW-1:0]    rel_idx;
    logic [IDXW-1:0]    ptr_inc;
    logic               sweep_last;
    logic [IDXW+15:0]   prod;
    logic [PW-1:0]      prod_w;

    assign cfg_count_cw = CW'(cfg_data[8:0]);
    always_comb
    begin
        if (cfg_count_cw == '0)
        begin
            count_clamped = CW'(1);
        end
        else if (cfg_count_cw > CW'(MAX_BLOCKS))
        begin
            count_clamped = CW'(MAX_BLOCKS);
        end
        else
        begin
            count_clamped = cfg_count_cw;
        end
    end

    assign idx_cw = CW'(req_index);
    assign rel_idx = idx_cw[IDXW-1:0];
    assign ptr_cw = CW'(ptr_reg);
    assign head_cw = CW'(head_reg);
    assign ptr_inc = IDXW'(ptr_reg + 1);
    assign sweep_last = (ptr_cw + CW'(1)) == CW'(count_reg);

    assign prod = head_reg * size_reg;
    assign prod_w = PW'(prod);

    assign stat.sweep_last = sweep_last;
    assign stat.list_empty = empty_reg;
    assign stat.range_err = idx_cw >= CW'(count_reg);
    assign rsp = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
        begin
            link_mem[ptr_reg] <= sweep_last ? {1'b1, {IDXW{1'b0}}} : {1'b0, ptr_inc};
        end
        else if (cmd.push)
        begin
            link_mem[rel_idx] <= {empty_reg, head_reg};
        end
        if (cmd.pop_read)
        begin
            rd_data_reg <= link_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            empty_reg <= 1'b0;
            ptr_reg <= '0;
            count_reg <= CNTW'(POOL_BLOCKS_RST > MAX_BLOCKS ? MAX_BLOCKS : POOL_BLOCKS_RST);
            size_reg <= BLOCK_SIZE_RST;
        end
        else
        begin
            if (cfg_count_wr)
            begin
                count_reg <= CNTW'(count_clamped);
            end
            if (cfg_size_wr)
            begin
                size_reg <= cfg_data[15:0];
            end
            if (cmd.sweep_start)
            begin
                ptr_reg <= '0;
                head_reg <= '0;
                empty_reg <= 1'b0;
            end
            else if (cmd.sweep_step)
            begin
                ptr_reg <= ptr_inc;
            end
            else if (cmd.pop_done)
            begin
                head_reg <= rd_data_reg[IDXW-1:0];
                empty_reg <= rd_data_reg[IDXW];
            end
            else if (cmd.push)
            begin
                head_reg <= rel_idx;
                empty_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop_done)
        begin
            rsp_reg.status <= ST_OK;
            rsp_reg.granted_index <= head_cw[7:0];
            rsp_reg.granted_offset <= prod_w[23:0];
        end
        else if (cmd.push || cmd.flag_empty || cmd.flag_range)
        begin
            rsp_reg.status <= cmd.flag_empty ? ST_EMPTY : (cmd.flag_range ? ST_RANGE : ST_OK);
            rsp_reg.granted_index <= '0;
            rsp_reg.granted_offset <= '0;
        end
    end

endmodule

`default_nettype wire

>>> src/fixed_block_free_list_allocator.sv
`default_nettype none

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_item (func, block_index)
// rsp       out        rsp_valid/rsp_stall   rsp_item (status, granted_index, granted_offset)
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// allocate: the head's link entry is registered at accept, then S_READ loads the head from it
// release and rejected items finish at accept; a release writes the link and moves the head
// a sweep writes one chain link per cycle, one link per block in use; req_stall is high
// through it after reset, and also while the pool size is written
// cfg writes are always taken
// a result held by rsp_stall blocks the next item until the output register drains
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire fbfl_pkg::req_t                      req_item,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output fbfl_pkg::rsp_t                           rsp_item,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fbfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fbfl_pkg::*;

    cmd_t cmd;
    stat_t stat;
    logic cfg_count_wr;
    logic cfg_size_wr;

    assign cfg_ready = 1'b1;
    assign cfg_count_wr = cfg_valid && (cfg_index == CFG_POOL_BLOCKS);
    assign cfg_size_wr = cfg_valid && (cfg_index == CFG_BLOCK_SIZE);

    fbfl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_func     (req_item.func),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .cfg_count_wr (cfg_count_wr),
        .stat         (stat),
        .cmd          (cmd)
    );

    fbfl_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_count_wr (cfg_count_wr),
        .cfg_size_wr  (cfg_size_wr),
        .cfg_data     (cfg_data),
        .req_index    (req_item.block_index),
        .rsp          (rsp_item)
    );

endmodule

`default_nettype wire
